### sv/cau_pkg.sv
// ----------------------------------------------------------------------------
// cau_pkg: shared types and constants of the complex arithmetic unit
// Opcode and order codes, operation classes and the queue control bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package cau_pkg;

    // default datapath format, signed Q8.8
    localparam int DATA_WIDTH_DEF = 16;
    localparam int FRAC_BITS_DEF  = 8;

    // depth of the queue between front and back
    localparam int QDEPTH = 2;

    // opcodes
    localparam logic [2:0] OP_ADD = 3'd0;
    localparam logic [2:0] OP_SUB = 3'd1;
    localparam logic [2:0] OP_MUL = 3'd2;
    localparam logic [2:0] OP_DIV = 3'd3;
    localparam logic [2:0] OP_CMP = 3'd4;

    // modulus compare codes
    localparam logic [1:0] ORD_LESS    = 2'd0;
    localparam logic [1:0] ORD_EQUAL   = 2'd1;
    localparam logic [1:0] ORD_GREATER = 2'd2;

    // operation class decided by the front
    typedef enum logic [2:0] {
        CLS_ADD,
        CLS_SUB,
        CLS_MUL,
        CLS_DIV,
        CLS_CMP,
        CLS_NOP
    } cls_t;

    // queue head status toward the back
    typedef struct packed {
        logic valid;
        cls_t cls;
    } qctl_t;

endpackage

`default_nettype wire

### sv/complex_arithmetic_unit.sv
// Path: queue, stage A, stage B, divider, output register; default format signed Q8.8.
// Throughput: one item per cycle unless the output stalls; the divider is a pipeline of DATA_WIDTH + 2
// stages that each settle one quotient bit, and every opcode flows through it.
// A two-entry queue after the front lets input beats land during output stalls.
// Reset: synchronous, active low aresetn; clears valid flags and queue pointers.
// ----------------------------------------------------------------------------
// complex_arithmetic_unit: complex ALU in signed fixed point
// Add, subtract, multiply, divide and modulus compare of two complex
// operands, with saturation and divide-by-zero flags.
// ----------------------------------------------------------------------------
`default_nettype none

module complex_arithmetic_unit
    import cau_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         s_valid,
    output logic                              s_ready,
    input  wire logic [2:0]                   s_opcode,
    input  wire logic signed [DATA_WIDTH-1:0] s_a_re,
    input  wire logic signed [DATA_WIDTH-1:0] s_a_im,
    input  wire logic signed [DATA_WIDTH-1:0] s_b_re,
    input  wire logic signed [DATA_WIDTH-1:0] s_b_im,
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output logic signed [DATA_WIDTH-1:0]      m_res_re,
    output logic signed [DATA_WIDTH-1:0]      m_res_im,
    output logic [1:0]                        m_order,
    output logic                              m_div_zero,
    output logic                              m_saturated
);

    qctl_t                        q_ctl;
    logic                         q_ready;
    logic signed [DATA_WIDTH-1:0] q_a_re, q_a_im, q_b_re, q_b_im;

    // decode and queue
    cau_front #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_opcode (s_opcode),
        .s_a_re   (s_a_re),
        .s_a_im   (s_a_im),
        .s_b_re   (s_b_re),
        .s_b_im   (s_b_im),
        .q_ctl    (q_ctl),
        .q_ready  (q_ready),
        .q_a_re   (q_a_re),
        .q_a_im   (q_a_im),
        .q_b_re   (q_b_re),
        .q_b_im   (q_b_im)
    );

    // execution pipeline
    cau_back #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_ctl       (q_ctl),
        .q_ready     (q_ready),
        .q_a_re      (q_a_re),
        .q_a_im      (q_a_im),
        .q_b_re      (q_b_re),
        .q_b_im      (q_b_im),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_res_re    (m_res_re),
        .m_res_im    (m_res_im),
        .m_order     (m_order),
        .m_div_zero  (m_div_zero),
        .m_saturated (m_saturated)
    );

endmodule

`default_nettype wire

### sv/cau_front.sv
// ----------------------------------------------------------------------------
// cau_front: input side of the complex arithmetic unit
// Accepts beats, decodes the opcode into an operation class and holds
// them in a small queue until the back pipeline takes them.
// ----------------------------------------------------------------------------
`default_nettype none

module cau_front
    import cau_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         s_valid,
    output logic                              s_ready,
    input  wire logic [2:0]                   s_opcode,
    input  wire logic signed [DATA_WIDTH-1:0] s_a_re,
    input  wire logic signed [DATA_WIDTH-1:0] s_a_im,
    input  wire logic signed [DATA_WIDTH-1:0] s_b_re,
    input  wire logic signed [DATA_WIDTH-1:0] s_b_im,
    output qctl_t                             q_ctl,
    input  wire logic                         q_ready,
    output logic signed [DATA_WIDTH-1:0]      q_a_re,
    output logic signed [DATA_WIDTH-1:0]      q_a_im,
    output logic signed [DATA_WIDTH-1:0]      q_b_re,
    output logic signed [DATA_WIDTH-1:0]      q_b_im
);

    localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int CNT_W = $clog2(QDEPTH + 1);

    // queue storage
    cls_t                        cls_mem [QDEPTH];
    logic signed [DATA_WIDTH-1:0] are_mem [QDEPTH];
    logic signed [DATA_WIDTH-1:0] aim_mem [QDEPTH];
    logic signed [DATA_WIDTH-1:0] bre_mem [QDEPTH];
    logic signed [DATA_WIDTH-1:0] bim_mem [QDEPTH];

    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             push, pop;
    cls_t             cls_dec;

    // opcode decode
    always_comb begin
        unique case (s_opcode)
            OP_ADD:  cls_dec = CLS_ADD;
            OP_SUB:  cls_dec = CLS_SUB;
            OP_MUL:  cls_dec = CLS_MUL;
            OP_DIV:  cls_dec = CLS_DIV;
            OP_CMP:  cls_dec = CLS_CMP;
            default: cls_dec = CLS_NOP;
        endcase
    end

    assign s_ready = (cnt_reg != CNT_W'(QDEPTH));
    assign push    = s_valid && s_ready;
    assign pop     = q_ctl.valid && q_ready;

    // pointer and fill count
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // entry write
    always_ff @(posedge aclk) begin
        if (push) begin
            cls_mem[wr_ptr_reg] <= cls_dec;
            are_mem[wr_ptr_reg] <= s_a_re;
            aim_mem[wr_ptr_reg] <= s_a_im;
            bre_mem[wr_ptr_reg] <= s_b_re;
            bim_mem[wr_ptr_reg] <= s_b_im;
        end
    end

    // queue head
    assign q_ctl.valid = (cnt_reg != '0);
    assign q_ctl.cls   = cls_mem[rd_ptr_reg];
    assign q_a_re      = are_mem[rd_ptr_reg];
    assign q_a_im      = aim_mem[rd_ptr_reg];
    assign q_b_re      = bre_mem[rd_ptr_reg];
    assign q_b_im      = bim_mem[rd_ptr_reg];

endmodule

`default_nettype wire

### sv/cau_back.sv
// ----------------------------------------------------------------------------
// cau_back: execution pipeline of the complex arithmetic unit
// Products, sums and saturation, then a restoring divider with one
// quotient bit per stage, then the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module cau_back
    import cau_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire qctl_t                        q_ctl,
    output logic                              q_ready,
    input  wire logic signed [DATA_WIDTH-1:0] q_a_re,
    input  wire logic signed [DATA_WIDTH-1:0] q_a_im,
    input  wire logic signed [DATA_WIDTH-1:0] q_b_re,
    input  wire logic signed [DATA_WIDTH-1:0] q_b_im,
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output logic signed [DATA_WIDTH-1:0]      m_res_re,
    output logic signed [DATA_WIDTH-1:0]      m_res_im,
    output logic [1:0]                        m_order,
    output logic                              m_div_zero,
    output logic                              m_saturated
);

    localparam int DW  = DATA_WIDTH;
    localparam int PW  = 2 * DATA_WIDTH;
    localparam int PW1 = PW + 1;
    localparam int SW  = DATA_WIDTH + 1;
    localparam int NS  = DATA_WIDTH + 2;
    localparam int QW  = DATA_WIDTH + 2;
    localparam int WW  = 3 * DATA_WIDTH + FRAC_BITS + 2;

    localparam logic [DW-1:0] MAXV = {1'b0, {(DW-1){1'b1}}};
    localparam logic [DW-1:0] MINV = {1'b1, {(DW-1){1'b0}}};
    localparam logic signed [PW:0] HI_W = {{(PW-DW+2){1'b0}}, {(DW-1){1'b1}}};
    localparam logic signed [PW:0] LO_W = {{(PW-DW+2){1'b1}}, {(DW-1){1'b0}}};
    localparam logic [QW-1:0] HALF_Q = QW'(1) << (DW - 1);

    // saturate a signed value; returns {sat, value}
    function automatic logic [DW:0] clamp_s(input logic signed [PW:0] x);
        if (x > HI_W) begin
            return {1'b1, MAXV};
        end else if (x < LO_W) begin
            return {1'b1, MINV};
        end
        return {1'b0, x[DW-1:0]};
    endfunction

    // saturate a sign and magnitude value; returns {sat, value}
    function automatic logic [DW:0] clamp_m(input logic neg, input logic [QW-1:0] q);
        logic [QW-1:0] nq;
        nq = -q;
        if (neg) begin
            if (q > HALF_Q) begin
                return {1'b1, MINV};
            end
            return {1'b0, nq[DW-1:0]};
        end
        if (q > HALF_Q - 1'b1) begin
            return {1'b1, MAXV};
        end
        return {1'b0, q[DW-1:0]};
    endfunction

    logic adv;
    logic out_vld_reg;

    // whole pipeline moves unless the output beat is stuck
    assign adv     = !out_vld_reg || m_ready;
    assign q_ready = adv;

    // ---------------- stage A: products and add/sub ----------------
    logic                  a_vld_reg;
    cls_t                  a_cls_reg;
    logic signed [PW-1:0]  p_rr_reg, p_ii_reg, p_ir_reg, p_ri_reg;
    logic signed [PW-1:0]  p_bbr_reg, p_bbi_reg, p_aar_reg, p_aai_reg;
    logic signed [SW-1:0]  s_re_reg, s_im_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_vld_reg <= 1'b0;
        end else if (adv) begin
            a_vld_reg <= q_ctl.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            a_cls_reg <= q_ctl.cls;
            p_rr_reg  <= PW'(q_a_re) * PW'(q_b_re);
            p_ii_reg  <= PW'(q_a_im) * PW'(q_b_im);
            p_ir_reg  <= PW'(q_a_im) * PW'(q_b_re);
            p_ri_reg  <= PW'(q_a_re) * PW'(q_b_im);
            p_bbr_reg <= PW'(q_b_re) * PW'(q_b_re);
            p_bbi_reg <= PW'(q_b_im) * PW'(q_b_im);
            p_aar_reg <= PW'(q_a_re) * PW'(q_a_re);
            p_aai_reg <= PW'(q_a_im) * PW'(q_a_im);
            if (q_ctl.cls == CLS_SUB) begin
                s_re_reg <= SW'(q_a_re) - SW'(q_b_re);
                s_im_reg <= SW'(q_a_im) - SW'(q_b_im);
            end else begin
                s_re_reg <= SW'(q_a_re) + SW'(q_b_re);
                s_im_reg <= SW'(q_a_im) + SW'(q_b_im);
            end
        end
    end

    // ---------------- stage B: sums, saturation, divider setup ----------------
    logic [NS:0]           vld_reg;
    cls_t                  cls_reg  [NS+1];
    logic [DW-1:0]         fre_reg  [NS+1];
    logic [DW-1:0]         fim_reg  [NS+1];
    logic [1:0]            ford_reg [NS+1];
    logic                  fsat_reg [NS+1];
    logic                  dz_reg   [NS+1];
    logic                  nre_reg  [NS+1];
    logic                  nim_reg  [NS+1];
    logic [WW-1:0]         rre_reg  [NS+1];
    logic [WW-1:0]         rim_reg  [NS+1];
    logic [QW-1:0]         qre_reg  [NS+1];
    logic [QW-1:0]         qim_reg  [NS+1];
    logic [PW-1:0]         den_reg  [NS+1];

    logic signed [PW:0] mre, mim, dre, dim;
    logic [PW:0]        dre_mag, dim_mag;
    logic [PW-1:0]      den_b, ma_b;
    logic [DW:0]        cre, cim;
    logic [DW-1:0]      fre_next, fim_next;
    logic [1:0]         ford_next;
    logic               fsat_next;

    always_comb begin
        mre = PW1'(p_rr_reg) - PW1'(p_ii_reg);
        mim = PW1'(p_ir_reg) + PW1'(p_ri_reg);
        dre = PW1'(p_rr_reg) + PW1'(p_ii_reg);
        dim = PW1'(p_ir_reg) - PW1'(p_ri_reg);
        dre_mag = dre[PW] ? PW1'(-dre) : PW1'(dre);
        dim_mag = dim[PW] ? PW1'(-dim) : PW1'(dim);
        den_b = $unsigned(p_bbr_reg) + $unsigned(p_bbi_reg);
        ma_b  = $unsigned(p_aar_reg) + $unsigned(p_aai_reg);
        cre = '0;
        cim = '0;
        fre_next  = '0;
        fim_next  = '0;
        ford_next = ORD_LESS;
        fsat_next = 1'b0;
        unique case (a_cls_reg) inside
            CLS_ADD, CLS_SUB: begin
                cre = clamp_s(PW1'(s_re_reg));
                cim = clamp_s(PW1'(s_im_reg));
                fre_next  = cre[DW-1:0];
                fim_next  = cim[DW-1:0];
                fsat_next = cre[DW] | cim[DW];
            end
            CLS_MUL: begin
                cre = clamp_s(mre >>> FRAC_BITS);
                cim = clamp_s(mim >>> FRAC_BITS);
                fre_next  = cre[DW-1:0];
                fim_next  = cim[DW-1:0];
                fsat_next = cre[DW] | cim[DW];
            end
            CLS_CMP: begin
                if (ma_b < den_b) begin
                    ford_next = ORD_LESS;
                end else if (ma_b == den_b) begin
                    ford_next = ORD_EQUAL;
                end else begin
                    ford_next = ORD_GREATER;
                end
            end
            default: begin
                fsat_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg[0] <= 1'b0;
        end else if (adv) begin
            vld_reg[0] <= a_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            cls_reg[0]  <= a_cls_reg;
            fre_reg[0]  <= fre_next;
            fim_reg[0]  <= fim_next;
            ford_reg[0] <= ford_next;
            fsat_reg[0] <= fsat_next;
            dz_reg[0]   <= (a_cls_reg == CLS_DIV) && (den_b == '0);
            nre_reg[0]  <= dre[PW];
            nim_reg[0]  <= dim[PW];
            rre_reg[0]  <= WW'(dre_mag) << FRAC_BITS;
            rim_reg[0]  <= WW'(dim_mag) << FRAC_BITS;
            qre_reg[0]  <= '0;
            qim_reg[0]  <= '0;
            den_reg[0]  <= den_b;
        end
    end

    // ---------------- divider: one quotient bit per stage ----------------
    // The top quotient bit flags a quotient beyond range; it forces saturation.
    for (genvar k = 0; k < NS; k++) begin : g_div
        localparam int BIT = NS - 1 - k;
        logic [WW-1:0] trial;
        logic [WW-1:0] rre_next, rim_next;
        logic [QW-1:0] qre_next, qim_next;

        always_comb begin
            trial    = WW'(den_reg[k]) << BIT;
            rre_next = rre_reg[k];
            rim_next = rim_reg[k];
            qre_next = qre_reg[k];
            qim_next = qim_reg[k];
            if (rre_reg[k] >= trial) begin
                rre_next      = rre_reg[k] - trial;
                qre_next[BIT] = 1'b1;
            end
            if (rim_reg[k] >= trial) begin
                rim_next      = rim_reg[k] - trial;
                qim_next[BIT] = 1'b1;
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k+1] <= 1'b0;
            end else if (adv) begin
                vld_reg[k+1] <= vld_reg[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                cls_reg[k+1]  <= cls_reg[k];
                fre_reg[k+1]  <= fre_reg[k];
                fim_reg[k+1]  <= fim_reg[k];
                ford_reg[k+1] <= ford_reg[k];
                fsat_reg[k+1] <= fsat_reg[k];
                dz_reg[k+1]   <= dz_reg[k];
                nre_reg[k+1]  <= nre_reg[k];
                nim_reg[k+1]  <= nim_reg[k];
                rre_reg[k+1]  <= rre_next;
                rim_reg[k+1]  <= rim_next;
                qre_reg[k+1]  <= qre_next;
                qim_reg[k+1]  <= qim_next;
                den_reg[k+1]  <= den_reg[k];
            end
        end
    end

    // ---------------- output register ----------------
    logic [DW:0]    ore, oim;
    logic [DW-1:0]  res_re_next, res_im_next;
    logic [1:0]     ord_next;
    logic           dz_next, sat_next;
    logic [DW-1:0]  res_re_reg, res_im_reg;
    logic [1:0]     ord_reg;
    logic           dz_out_reg, sat_reg;

    always_comb begin
        ore = clamp_m(nre_reg[NS], qre_reg[NS]);
        oim = clamp_m(nim_reg[NS], qim_reg[NS]);
        if (cls_reg[NS] == CLS_DIV) begin
            ord_next = ORD_LESS;
            if (dz_reg[NS]) begin
                res_re_next = '0;
                res_im_next = '0;
                dz_next     = 1'b1;
                sat_next    = 1'b0;
            end else begin
                res_re_next = ore[DW-1:0];
                res_im_next = oim[DW-1:0];
                dz_next     = 1'b0;
                sat_next    = ore[DW] | oim[DW];
            end
        end else begin
            res_re_next = fre_reg[NS];
            res_im_next = fim_reg[NS];
            ord_next    = ford_reg[NS];
            dz_next     = 1'b0;
            sat_next    = fsat_reg[NS];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (adv) begin
            out_vld_reg <= vld_reg[NS];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            res_re_reg <= res_re_next;
            res_im_reg <= res_im_next;
            ord_reg    <= ord_next;
            dz_out_reg <= dz_next;
            sat_reg    <= sat_next;
        end
    end

    assign m_valid     = out_vld_reg;
    assign m_res_re    = res_re_reg;
    assign m_res_im    = res_im_reg;
    assign m_order     = ord_reg;
    assign m_div_zero  = dz_out_reg;
    assign m_saturated = sat_reg;

`ifndef SYNTHESIS
    // zero divisor gives zero parts and no clamp
    a_dz_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_div_zero |-> m_res_re == '0 && m_res_im == '0 && !m_saturated)
        else $error("div_zero beat with nonzero result");

    // compare result carries no arithmetic result
    a_cmp_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_order != ORD_LESS |-> m_res_re == '0 && m_res_im == '0
            && !m_saturated && !m_div_zero)
        else $error("compare beat with arithmetic fields set");

    // order code stays in range
    a_ord_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_order == ORD_LESS || m_order == ORD_EQUAL || m_order == ORD_GREATER)
        else $error("order code out of range");

    // a stalled output beat stops the queue from being drained
    a_stall_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |-> !q_ready)
        else $error("pipeline advanced under output stall");
`endif

endmodule

`default_nettype wire
